// File: design/scrm_pkg.sv
// Package for the sparse coordinate region mapper.
// Holds the item, region and code types shared by the front, queue, back and top level.
// No dependencies.
package scrm_pkg;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] CFG_ROWS_IN_USE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FEATURES_IN_USE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REGIONS_IN_USE  = 2'd2;

  // Depth of the queue between front and back; a power of two.
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    REQ_ROW_MAP  = 2'd0,
    REQ_FEAT_MAP = 2'd1,
    REQ_REGION   = 2'd2,
    REQ_COORD    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BOUNDS    = 2'd1,
    ST_ORDER     = 2'd2,
    ST_NO_REGION = 2'd3
  } status_e;

  // One input item as it arrives on the ports.
  typedef struct packed {
    req_e        kind;
    logic [11:0] tidx;
    logic [11:0] tval;
    logic [11:0] row;
    logic [11:0] feat;
    logic [12:0] rext;
    logic [12:0] fext;
    logic [15:0] label;
    logic        disc;
    logic [31:0] value;
    logic        last;
  } scrm_req_t;

  // A classified item as it travels through the queue.
  typedef struct packed {
    scrm_req_t req;
    status_e   status;
  } scrm_item_t;

  // One region table entry.
  typedef struct packed {
    logic [11:0] row_base;
    logic [12:0] row_span;
    logic [11:0] feat_base;
    logic [12:0] feat_span;
    logic [15:0] label;
    logic        disc;
  } region_t;

endpackage

// File: design/scrm_front.sv
// Front end of the sparse coordinate region mapper: classifies items and checks coordinates.
// Depends on scrm_pkg.
module scrm_front import scrm_pkg::*; #(
  parameter int MAX_ROWS     = 4096,
  parameter int MAX_FEATURES = 4096,
  parameter int MAX_REGIONS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  scrm_req_t         req_i,
  input  logic [12:0]       rows_in_use_i,
  input  logic [12:0]       features_in_use_i,
  output logic              q_push_o,
  output scrm_item_t        q_item_o
);

  logic [11:0] last_row_q, last_row_d;
  logic [11:0] last_feat_q, last_feat_d;
  logic        have_last_q, have_last_d;

  logic    keep;
  logic    oob;
  logic    ooo;
  status_e status;
  logic [31:0] tidx_w, row_w, feat_w;

  assign tidx_w = 32'(req_i.tidx);
  assign row_w  = 32'(req_i.row);
  assign feat_w = 32'(req_i.feat);

  always_comb begin
    unique case (req_i.kind)
      REQ_ROW_MAP:  keep = tidx_w < 32'(MAX_ROWS);
      REQ_FEAT_MAP: keep = tidx_w < 32'(MAX_FEATURES);
      REQ_REGION:   keep = tidx_w < 32'(MAX_REGIONS);
      default:      keep = 1'b1;
    endcase
  end

  // Bounds are the smaller of the register and the table size.
  assign oob = (row_w >= 32'(rows_in_use_i)) || (row_w >= 32'(MAX_ROWS)) ||
               (feat_w >= 32'(features_in_use_i)) || (feat_w >= 32'(MAX_FEATURES));

  assign ooo = have_last_q && ((req_i.row < last_row_q) ||
               ((req_i.row == last_row_q) && (req_i.feat <= last_feat_q)));

  always_comb begin
    priority if (oob) begin
      status = ST_BOUNDS;
    end else if (ooo) begin
      status = ST_ORDER;
    end else begin
      status = ST_OK;
    end
  end

  assign q_push_o        = push_i && keep;
  assign q_item_o.req    = req_i;
  assign q_item_o.status = status;

  always_comb begin
    last_row_d  = last_row_q;
    last_feat_d = last_feat_q;
    have_last_d = have_last_q;
    if (push_i && (req_i.kind == REQ_COORD)) begin
      if (req_i.last) begin
        last_row_d  = '0;
        last_feat_d = '0;
        have_last_d = 1'b0;
      end else if (status == ST_OK) begin
        last_row_d  = req_i.row;
        last_feat_d = req_i.feat;
        have_last_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_row_q  <= '0;
      last_feat_q <= '0;
      have_last_q <= 1'b0;
    end else begin
      last_row_q  <= last_row_d;
      last_feat_q <= last_feat_d;
      have_last_q <= have_last_d;
    end
  end

  a_history_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_last_q |-> (last_row_q == '0) && (last_feat_q == '0))
    else $error("ordering history not cleared");

  a_order_needs_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && (req_i.kind == REQ_COORD) && (status == ST_ORDER)) |-> have_last_q)
    else $error("order error flagged without history");

endmodule

// File: design/scrm_queue.sv
// Short queue of classified items between the front and the back.
// Depends on scrm_pkg.
module scrm_queue import scrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  scrm_item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output scrm_item_t item_o
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  scrm_item_t          slot_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       count_q;
  logic                do_push, do_pop;

  assign full_o  = count_q == (PtrW+1)'(QDepth);
  assign valid_o = count_q != '0;
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(QDepth))
    else $error("queue count beyond depth");

endmodule

// File: design/scrm_back.sv
// Back end of the sparse coordinate region mapper: remap memories, region table and search.
// Depends on scrm_pkg.
module scrm_back import scrm_pkg::*; #(
  parameter int MAX_ROWS     = 4096,
  parameter int MAX_FEATURES = 4096,
  parameter int MAX_REGIONS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  scrm_item_t  q_item_i,
  output logic        q_pop_o,
  input  logic [4:0]  regions_in_use_i,
  output logic        out_valid_o,
  input  logic        out_pop_i,
  output logic [11:0] src_row_o,
  output logic [11:0] src_feature_o,
  output logic [11:0] packed_row_o,
  output logic [11:0] packed_feature_o,
  output logic [15:0] region_found_o,
  output logic [31:0] carried_value_o,
  output status_e     status_o
);

  localparam int RowAw  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int FeatAw = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int RegAw  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  logic [11:0] row_mem_q  [MAX_ROWS];
  logic [11:0] feat_mem_q [MAX_FEATURES];
  region_t     region_q   [MAX_REGIONS];

  logic [11:0] row_rd_q, feat_rd_q;
  logic        s1_valid_q;
  scrm_item_t  s1_item_q;
  logic        out_valid_q;

  logic        s1_adv, s1_ready, take;
  logic        row_we, feat_we, region_we, rd_en;
  logic [RowAw-1:0]  row_waddr, row_raddr;
  logic [FeatAw-1:0] feat_waddr, feat_raddr;
  logic [RegAw-1:0]  region_waddr;
  logic [MAX_REGIONS-1:0] hit;
  logic        any_hit;
  logic [15:0] hit_label;
  region_t     region_new;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_pop_i);
  assign s1_ready = !s1_valid_q || s1_adv;
  assign take     = q_valid_i && s1_ready;
  assign q_pop_o  = take;

  assign row_we    = take && (q_item_i.req.kind == REQ_ROW_MAP);
  assign feat_we   = take && (q_item_i.req.kind == REQ_FEAT_MAP);
  assign region_we = take && (q_item_i.req.kind == REQ_REGION);
  assign rd_en     = take && (q_item_i.req.kind == REQ_COORD) && (q_item_i.status == ST_OK);

  // The front has dropped loads beyond the tables, so the truncations keep every bit in use.
  assign row_waddr    = RowAw'(32'(q_item_i.req.tidx));
  assign feat_waddr   = FeatAw'(32'(q_item_i.req.tidx));
  assign region_waddr = RegAw'(32'(q_item_i.req.tidx));
  assign row_raddr    = RowAw'(32'(q_item_i.req.row));
  assign feat_raddr   = FeatAw'(32'(q_item_i.req.feat));

  assign region_new.row_base  = q_item_i.req.row;
  assign region_new.row_span  = q_item_i.req.rext;
  assign region_new.feat_base = q_item_i.req.feat;
  assign region_new.feat_span = q_item_i.req.fext;
  assign region_new.label     = q_item_i.req.label;
  assign region_new.disc      = q_item_i.req.disc;

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem_q[row_waddr] <= q_item_i.req.tval;
    end
    if (rd_en) begin
      row_rd_q <= row_mem_q[row_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (feat_we) begin
      feat_mem_q[feat_waddr] <= q_item_i.req.tval;
    end
    if (rd_en) begin
      feat_rd_q <= feat_mem_q[feat_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (region_we) begin
      region_q[region_waddr] <= region_new;
    end
  end

  // All regions are compared side by side; the lowest hit wins.
  always_comb begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      hit[i] = (32'(i) < 32'(regions_in_use_i)) && !region_q[i].disc &&
               (row_rd_q >= region_q[i].row_base) &&
               (14'(row_rd_q) < 14'(region_q[i].row_base) + 14'(region_q[i].row_span)) &&
               (feat_rd_q >= region_q[i].feat_base) &&
               (14'(feat_rd_q) < 14'(region_q[i].feat_base) + 14'(region_q[i].feat_span));
    end
  end

  always_comb begin
    any_hit   = 1'b0;
    hit_label = '0;
    for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit   = 1'b1;
        hit_label = region_q[i].label;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take && (q_item_i.req.kind == REQ_COORD)) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && (q_item_i.req.kind == REQ_COORD)) begin
      s1_item_q <= q_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      src_row_o       <= s1_item_q.req.row;
      src_feature_o   <= s1_item_q.req.feat;
      carried_value_o <= s1_item_q.req.value;
      if (s1_item_q.status == ST_OK) begin
        packed_row_o     <= row_rd_q;
        packed_feature_o <= feat_rd_q;
        region_found_o   <= any_hit ? hit_label : '0;
        status_o         <= any_hit ? ST_OK : ST_NO_REGION;
      end else begin
        packed_row_o     <= '0;
        packed_feature_o <= '0;
        region_found_o   <= '0;
        status_o         <= s1_item_q.status;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((status_o == ST_BOUNDS) || (status_o == ST_ORDER))) |->
    (packed_row_o == '0) && (packed_feature_o == '0) && (region_found_o == '0))
    else $error("error result carries remapped data");

  a_no_region_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_o == ST_NO_REGION)) |-> (region_found_o == '0))
    else $error("no-region result carries a label");

endmodule

// File: design/sparse_coordinate_region_mapper_unit.sv
// Top level of the sparse coordinate region mapper.
// Depends on scrm_pkg, scrm_front, scrm_queue and scrm_back.
//
// This unit maps sparse-matrix coordinates into a packed layout. Load items
// (row map, feature map, region) fill the tables and produce no result; each
// coordinate item produces exactly one result with a status: ok, out of
// bounds, out of order or no region. The front end classifies every item as
// it is accepted, checks bounds and strict row-major ordering against the
// last good coordinate, and keeps that history; a two-entry queue then hands
// items to the back end, which applies loads in order, reads both remap
// memories in the same cycle and compares the remapped point against every region
// side by side. Items are taken one per clock as long as the queue has room,
// and a coordinate passes from the queue into the back end's first stage,
// where both remap memories are read, and then into the result register.
// Each stage handles one item per cycle and each remap memory needs one read
// per coordinate, so the sustained rate is one item per cycle; only a stalled
// result register holds the back end and, once the queue fills, the input.
// The tables have no reset and need no clearing pass: a coordinate must not
// reach a remap entry or a region that was never loaded. Configuration
// registers may only be written while the unit is idle.
module sparse_coordinate_region_mapper_unit import scrm_pkg::*; #(
  parameter int MAX_ROWS     = 4096,
  parameter int MAX_FEATURES = 4096,
  parameter int MAX_REGIONS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          req_type_i,
  input  logic [11:0]         table_index_i,
  input  logic [11:0]         table_value_i,
  input  logic [11:0]         row_index_i,
  input  logic [11:0]         feature_index_i,
  input  logic [12:0]         row_extent_i,
  input  logic [12:0]         feature_extent_i,
  input  logic [15:0]         region_label_i,
  input  logic                region_discarded_i,
  input  logic [31:0]         entry_value_i,
  input  logic                last_item_i,
  output logic                empty,
  input  logic                pop,
  output logic [11:0]         src_row_o,
  output logic [11:0]         src_feature_o,
  output logic [11:0]         packed_row_o,
  output logic [11:0]         packed_feature_o,
  output logic [15:0]         region_found_o,
  output logic [31:0]         carried_value_o,
  output logic [1:0]          status_o
);

  logic [12:0] rows_in_use_q;
  logic [12:0] features_in_use_q;
  logic [4:0]  regions_in_use_q;

  scrm_req_t  req;
  scrm_item_t front_item, back_item;
  logic       front_push, q_full, q_valid, q_pop;
  logic       out_valid;
  status_e    status;

  // Configuration registers; index values outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_in_use_q     <= 13'd4096;
      features_in_use_q <= 13'd4096;
      regions_in_use_q  <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS_IN_USE:     rows_in_use_q     <= cfg_data_i;
        CFG_FEATURES_IN_USE: features_in_use_q <= cfg_data_i;
        CFG_REGIONS_IN_USE:  regions_in_use_q  <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  assign req.kind  = req_e'(req_type_i);
  assign req.tidx  = table_index_i;
  assign req.tval  = table_value_i;
  assign req.row   = row_index_i;
  assign req.feat  = feature_index_i;
  assign req.rext  = row_extent_i;
  assign req.fext  = feature_extent_i;
  assign req.label = region_label_i;
  assign req.disc  = region_discarded_i;
  assign req.value = entry_value_i;
  assign req.last  = last_item_i;

  assign full = q_full;

  scrm_front #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_REGIONS  (MAX_REGIONS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push && !q_full),
    .req_i             (req),
    .rows_in_use_i     (rows_in_use_q),
    .features_in_use_i (features_in_use_q),
    .q_push_o          (front_push),
    .q_item_o          (front_item)
  );

  scrm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (back_item)
  );

  scrm_back #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_REGIONS  (MAX_REGIONS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (back_item),
    .q_pop_o          (q_pop),
    .regions_in_use_i (regions_in_use_q),
    .out_valid_o      (out_valid),
    .out_pop_i        (pop && out_valid),
    .src_row_o        (src_row_o),
    .src_feature_o    (src_feature_o),
    .packed_row_o     (packed_row_o),
    .packed_feature_o (packed_feature_o),
    .region_found_o   (region_found_o),
    .carried_value_o  (carried_value_o),
    .status_o         (status)
  );

  assign empty    = !out_valid;
  assign status_o = status;

endmodule
